@@ sv/trimmed_block_average_unit_defines.svh @@
// Assertion macros for the RTL of the trimmed block average unit.
// Every property is clocked on clk_i and disabled while rst_ni is low.
`ifndef TRIMMED_BLOCK_AVERAGE_UNIT_DEFINES_SVH
`define TRIMMED_BLOCK_AVERAGE_UNIT_DEFINES_SVH

// Checks that a property holds at every rising clock edge.
`define TBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define TBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tba_pkg.sv @@
package tba_pkg;

  // Fixed port widths.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned STATUS_W = 2;

  // Parameter defaults for the top level.
  localparam int unsigned MAX_ITEMS_DEF   = 256;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EQUAL     = 2'd1,
    STAT_NO_MIDDLE = 2'd2,
    STAT_TOO_LONG  = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_LOAD
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc;
    logic prep;
    logic div_start;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_div;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

@@ sv/tba_div.sv @@
`include "trimmed_block_average_unit_defines.svh"

module tba_div #(
  parameter int unsigned DIVIDEND_W = 41,
  parameter int unsigned DIVISOR_W  = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial  = {rem_q, quo_q[DIVIDEND_W-1]};
    diff   = trial - {1'b0, divisor_i};
    fits   = (trial >= {1'b0, divisor_i});
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DIVIDEND_W);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d  = {quo_q[DIVIDEND_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Step counter and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  `TBA_ASSERT_NEXT(a_start_busy, start_i, busy_q && step_q == STEP_W'(DIVIDEND_W),
    "divider did not start a full pass")
  `TBA_ASSERT_NEXT(a_last_step, busy_q && !start_i && step_q == STEP_W'(1), !busy_q,
    "divider ran past its last step")
  `TBA_ASSERT(a_rem_bound, !busy_q || step_q == STEP_W'(DIVIDEND_W) || rem_q < divisor_i,
    "partial remainder is not below the divisor")

endmodule

@@ sv/tba_dp.sv @@
module tba_dp #(
  parameter int unsigned MAX_ITEMS   = 256,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tba_pkg::ctrl_cmd_t             cmd_i,
  output tba_pkg::dp_stat_t              stat_o,
  input  logic [tba_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [tba_pkg::OUT_W-1:0]      average_o,
  output logic [tba_pkg::STATUS_W-1:0]   status_o
);

  import tba_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;

  // Block accumulators.
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          ovf_q, ovf_d;
  logic signed [SAMPLE_BITS-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CNT_W-1:0]              lc_q, lc_d, hc_q, hc_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d, lsum_q, lsum_d, hsum_q, hsum_d;

  // End-of-block results.
  logic signed [SUM_W-1:0]       msum_q;
  logic [CNT_W-1:0]              mid_q;
  status_e                       res_stat_q, res_stat_d;

  // Output register.
  logic                          out_valid_q;
  logic [OUT_W-1:0]              average_q;
  status_e                       status_q;

  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [SUM_W-1:0]       smp_ext;
  logic [CNT_W-1:0]              middle;
  logic signed [SUM_W-1:0]       msum;
  logic [SUM_W-1:0]              mag;
  logic [SUM_W-1:0]              quo;
  logic                          div_busy;
  logic [SUM_W-1:0]              quo_signed;
  logic signed [SAMPLE_BITS-1:0] avg_sb;
  logic signed [OUT_W-1:0]       avg_ext;

  // Sample, read as two's complement in its low bits.
  assign smp     = $signed(sample_i[SAMPLE_BITS-1:0]);
  assign smp_ext = SUM_W'(smp);

  // Running sum, extremes and their counts and sums.
  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    lc_d   = lc_q;
    hc_d   = hc_q;
    sum_d  = sum_q;
    lsum_d = lsum_q;
    hsum_d = hsum_q;
    if (cmd_i.prep) begin
      cnt_d  = '0;
      ovf_d  = 1'b0;
      lo_d   = '0;
      hi_d   = '0;
      lc_d   = '0;
      hc_d   = '0;
      sum_d  = '0;
      lsum_d = '0;
      hsum_d = '0;
    end else if (cmd_i.acc && !ovf_q) begin
      if (cnt_q >= CNT_W'(MAX_ITEMS)) begin
        ovf_d = 1'b1;
      end else begin
        if (cnt_q == '0) begin
          lo_d   = smp;
          hi_d   = smp;
          lc_d   = CNT_W'(1);
          hc_d   = CNT_W'(1);
          lsum_d = smp_ext;
          hsum_d = smp_ext;
        end else begin
          if (smp < lo_q) begin
            lo_d   = smp;
            lc_d   = CNT_W'(1);
            lsum_d = smp_ext;
          end else if (smp == lo_q) begin
            lc_d   = lc_q + CNT_W'(1);
            lsum_d = lsum_q + smp_ext;
          end
          if (smp > hi_q) begin
            hi_d   = smp;
            hc_d   = CNT_W'(1);
            hsum_d = smp_ext;
          end else if (smp == hi_q) begin
            hc_d   = hc_q + CNT_W'(1);
            hsum_d = hsum_q + smp_ext;
          end
        end
        sum_d = sum_q + smp_ext;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      lo_q   <= '0;
      hi_q   <= '0;
      lc_q   <= '0;
      hc_q   <= '0;
      sum_q  <= '0;
      lsum_q <= '0;
      hsum_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      lc_q   <= lc_d;
      hc_q   <= hc_d;
      sum_q  <= sum_d;
      lsum_q <= lsum_d;
      hsum_q <= hsum_d;
    end
  end

  // Middle count, middle sum and the block status.
  always_comb begin
    middle = cnt_q - lc_q - hc_q;
    msum   = sum_q - lsum_q - hsum_q;
    if (ovf_q) begin
      res_stat_d = STAT_TOO_LONG;
    end else if (lo_q == hi_q) begin
      res_stat_d = STAT_EQUAL;
    end else if (middle == '0) begin
      res_stat_d = STAT_NO_MIDDLE;
    end else begin
      res_stat_d = STAT_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      msum_q     <= msum;
      mid_q      <= middle;
      res_stat_q <= res_stat_d;
    end
  end

  // Divide the magnitude of the middle sum by the middle count.
  assign mag = msum_q[SUM_W-1] ? SUM_W'(-msum_q) : SUM_W'(msum_q);

  tba_div #(
    .DIVIDEND_W(SUM_W),
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(mag),
    .divisor_i (mid_q),
    .busy_o    (div_busy),
    .quotient_o(quo)
  );

  // Restore the sign; the mean always fits the sample width.
  assign quo_signed = msum_q[SUM_W-1] ? (~quo + SUM_W'(1)) : quo;
  assign avg_sb     = $signed(quo_signed[SAMPLE_BITS-1:0]);
  assign avg_ext    = OUT_W'(avg_sb);

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      average_q <= (res_stat_q == STAT_OK) ? avg_ext : '0;
      status_q  <= res_stat_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign average_o        = average_q;
  assign status_o         = status_q;
  assign stat_o.needs_div = (res_stat_d == STAT_OK);
  assign stat_o.div_busy  = div_busy;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

@@ sv/tba_ctrl.sv @@
module tba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_i,
  output logic                in_ready_o,
  input  tba_pkg::dp_stat_t   stat_i,
  output tba_pkg::ctrl_cmd_t  cmd_o
);

  import tba_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_ACCUM: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (last_i) begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = stat_i.needs_div ? ST_START : ST_LOAD;
      end
      ST_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (!stat_i.div_busy && stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_ACCUM;
        end
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

endmodule

@@ sv/trimmed_block_average_unit.sv @@
// Samples without the last flag are accepted at a rate of one sample per cycle.
// On the last sample the result word for the all-equal, no-middle and too-long cases
// is loaded without a division; otherwise a division of the middle sum by the middle
// count runs first, one quotient bit per cycle, and its quotient is then loaded.
// Input ready is low from the last sample until the result enters the output register.
// Reset is asynchronous, active low, and clears the block state and the output valid.
module trimmed_block_average_unit #(
  parameter int unsigned MAX_ITEMS   = tba_pkg::MAX_ITEMS_DEF,
  parameter int unsigned SAMPLE_BITS = tba_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tba_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tba_pkg::OUT_W-1:0]    average_o,
  output logic [tba_pkg::STATUS_W-1:0] status_o
);

  import tba_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencing of accumulate, finish, divide and result load.
  tba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .last_i    (last_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Accumulators, divider and output register.
  tba_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .sample_i   (sample_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .average_o  (average_o),
    .status_o   (status_o)
  );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import tba_pkg::*;

  localparam int unsigned BLOCK_LIMIT  = MAX_ITEMS_DEF;
  localparam int unsigned TARGET_WORDS = 750;
  localparam int unsigned CALM_WORDS   = 150;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AT      = 12;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sample_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] average;
    status_e          status;
  } block_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [SAMPLE_W-1:0] sample_i    = '0;
  logic                last_i      = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [OUT_W-1:0]    average_o;
  logic [STATUS_W-1:0] status_o;

  sample_word_t  pending_words[$];
  block_result_t expected_results[$];

  // Running block state of the predictor.
  longint acc_sum;
  longint low_val;
  longint high_val;
  longint low_cnt;
  longint high_cnt;
  longint word_cnt;
  bit     overflow_seen;

  int unsigned word_total;
  int unsigned block_total;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned status_hits[4];
  int unsigned fail_count;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  bit          hold_done;
  sample_word_t  next_word;
  block_result_t want;

  trimmed_block_average_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .average_o   (average_o),
    .status_o    (status_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Idling is allowed outside the closing stretch, and not in every window of time.
  function automatic bit may_idle();
    return pending_words.size() >= CALM_WORDS && (($time / 1600) % 3) != 0;
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(int unsigned mode);
    logic [SAMPLE_W-1:0] v;
    v = $urandom;
    if (mode == 1) begin
      // Narrow range, so that ties with the minimum and maximum are common.
      v = $urandom_range(0, 6) - 3;
    end else if (mode == 2 && $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0: v = 32'h8000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'h0000_0000;
        default: v = 32'hFFFF_FFFF;
      endcase
    end
    return v;
  endfunction

  task automatic add_word(input logic [SAMPLE_W-1:0] v, input logic is_last);
    sample_word_t w;
    w.sample = v;
    w.last   = is_last;
    pending_words.push_back(w);
    word_total++;
    if (is_last) block_total++;
  endtask

  task automatic add_block(input int unsigned len);
    int unsigned mode;
    int unsigned r;
    r = $urandom_range(0, 9);
    mode = (r < 4) ? 0 : ((r < 8) ? 1 : 2);
    for (int unsigned i = 0; i < len; i++) begin
      add_word(draw_sample(mode), i == len - 1);
    end
  endtask

  task automatic clear_block();
    acc_sum       = 0;
    low_val       = 0;
    high_val      = 0;
    low_cnt       = 0;
    high_cnt      = 0;
    word_cnt      = 0;
    overflow_seen = 1'b0;
  endtask

  // Folds one accepted word into the block state; the last word yields the trimmed mean.
  task automatic absorb_sample(input logic [SAMPLE_W-1:0] raw, input logic is_last);
    longint s;
    longint middle;
    longint middle_sum;
    block_result_t res;
    s = longint'($signed(raw));
    if (!overflow_seen) begin
      if (word_cnt >= BLOCK_LIMIT) begin
        overflow_seen = 1'b1;
      end else begin
        if (word_cnt == 0) begin
          low_val  = s;
          high_val = s;
          low_cnt  = 1;
          high_cnt = 1;
        end else begin
          if (s < low_val) begin
            low_val = s;
            low_cnt = 1;
          end else if (s == low_val) begin
            low_cnt++;
          end
          if (s > high_val) begin
            high_val = s;
            high_cnt = 1;
          end else if (s == high_val) begin
            high_cnt++;
          end
        end
        acc_sum += s;
        word_cnt++;
      end
    end
    if (is_last) begin
      res.average = '0;
      if (overflow_seen) begin
        res.status = STAT_TOO_LONG;
      end else if (low_val == high_val) begin
        res.status = STAT_EQUAL;
      end else begin
        middle = word_cnt - low_cnt - high_cnt;
        if (middle == 0) begin
          res.status = STAT_NO_MIDDLE;
        end else begin
          middle_sum  = acc_sum - low_cnt * low_val - high_cnt * high_val;
          res.average = 32'(middle_sum / middle);
          res.status  = STAT_OK;
        end
      end
      expected_results.push_back(res);
      clear_block();
    end
  endtask

  // Driver: offers pending words, holding each one until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
      last_i     <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        absorb_sample(sample_i, last_i);
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (may_idle() && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 7);
          in_valid_i <= 1'b0;
        end else begin
          next_word = pending_words.pop_front();
          in_valid_i <= 1'b1;
          sample_i   <= next_word.sample;
          last_i     <= next_word.last;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest expectation and paces out_ready_i.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (!$isunknown(status_o)) status_hits[status_o]++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: average %0d status %0d", $signed(average_o), status_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (average_o !== want.average) begin
            $error("average: expected %0d, actual %0d",
                   $signed(want.average), $signed(average_o));
            fail_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            fail_count++;
          end
        end
        // Long hold-off so the block backs up and stalls its input.
        if (!hold_done && results_seen == HOLD_AT) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else if (may_idle() && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d cycles without a handshake", quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    clear_block();

    // Single-sample blocks at both extremes: all equal.
    add_word(32'h7FFF_FFFF, 1'b1);
    add_word(32'h8000_0000, 1'b1);
    // Several equal samples.
    add_word(32'd5, 1'b0);
    add_word(32'd5, 1'b0);
    add_word(32'd5, 1'b1);
    // Only minimum and maximum present: no middle.
    add_word(32'h8000_0000, 1'b0);
    add_word(32'h7FFF_FFFF, 1'b0);
    add_word(32'h8000_0000, 1'b0);
    add_word(32'h7FFF_FFFF, 1'b1);
    // Extremes around middle samples close to them.
    add_word(32'h8000_0000, 1'b0);
    add_word(32'h7FFF_FFFF, 1'b0);
    add_word(32'h7FFF_FFFE, 1'b0);
    add_word(32'h8000_0001, 1'b0);
    add_word(32'd100, 1'b1);
    // Negative middle mean that truncates toward zero.
    add_word(-32'sd7, 1'b0);
    add_word(32'd10, 1'b0);
    add_word(-32'sd3, 1'b0);
    add_word(-32'sd4, 1'b0);
    add_word(32'd10, 1'b1);
    // Plain case.
    add_word(32'd3, 1'b0);
    add_word(32'd1, 1'b0);
    add_word(32'd2, 1'b1);

    // Random blocks, mostly short; one of exactly the limit and one just over it.
    for (int unsigned blk = 0; word_total < TARGET_WORDS; blk++) begin
      if (blk == 10) begin
        add_block(BLOCK_LIMIT);
      end else if (blk == 30) begin
        add_block($urandom_range(BLOCK_LIMIT + 1, BLOCK_LIMIT + 8));
      end else if ($urandom_range(0, 15) == 0) begin
        add_block($urandom_range(11, 40));
      end else begin
        add_block($urandom_range(1, 10));
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples in %0d blocks, checked %0d results.",
             words_sent, block_total, results_seen);
    $display("Results by status: ok %0d, all equal %0d, no middle %0d, too long %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/tba_pkg.sv
sv/tba_div.sv
sv/tba_dp.sv
sv/tba_ctrl.sv
sv/trimmed_block_average_unit.sv
tb/sv/testbench.sv
